@@ sv/stun_binding_response_parser_defines.svh @@
// Assertion macros shared by the STUN binding response parser RTL.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef STUN_BINDING_RESPONSE_PARSER_DEFINES_SVH
`define STUN_BINDING_RESPONSE_PARSER_DEFINES_SVH

// Clocked check, switched off while reset is asserted.
`define STUNBR_CHECK(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Clocked check that also holds during reset.
`define STUNBR_CHECK_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ sv/stunbr_pkg.sv @@
// Shared types and constants for the STUN binding response parser.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package stunbr_pkg;

    localparam logic [31:0] STUN_COOKIE      = 32'h2112A442;
    localparam logic [15:0] MSG_BINDING_RESP = 16'h0101;
    localparam logic [15:0] ATTR_MAPPED      = 16'h0001;
    localparam logic [15:0] ATTR_XOR_MAPPED  = 16'h0020;
    localparam logic [7:0]  FAM_CODE_IPV4    = 8'h01;
    localparam logic [7:0]  FAM_CODE_IPV6    = 8'h02;

    localparam logic [1:0]  FAMILY_NONE = 2'd0;
    localparam logic [1:0]  FAMILY_IPV4 = 2'd1;
    localparam logic [1:0]  FAMILY_IPV6 = 2'd2;

    localparam int          POS_W     = 17;
    localparam logic [16:0] HDR_LEN   = 17'd20;
    localparam logic [16:0] POS_MAX   = 17'h1FFFF;
    localparam int          VAL_DEPTH = 20;
    localparam logic [15:0] V4_MIN_LEN = 16'd8;
    localparam logic [15:0] V6_MIN_LEN = 16'd20;

    // Configuration register indexes
    localparam logic REG_TXID_HIGH = 1'b0;
    localparam logic REG_TXID_LOW  = 1'b1;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_SHORT    = 3'd1,
        ST_BAD_TYPE = 3'd2,
        ST_BAD_MAGIC = 3'd3,
        ST_ID_MISMATCH = 3'd4,
        ST_OVERRUN  = 3'd5,
        ST_NO_ADDR  = 3'd6
    } status_t;

    typedef enum logic [3:0] {
        PH_HEAD  = 4'b0001,
        PH_VALUE = 4'b0010,
        PH_PAD   = 4'b0100,
        PH_STOP  = 4'b1000
    } phase_t;

    // One datagram word as it is processed this cycle
    typedef struct packed {
        logic             go;
        logic [7:0]       data;
        logic             last;
        logic [POS_W-1:0] idx;
    } step_t;

    // Header check results, next-state view
    typedef struct packed {
        status_t     fault;
        logic [15:0] total;
    } hdr_info_t;

    // Decoded addresses, next-state view
    typedef struct packed {
        logic        xor_found;
        logic [1:0]  xor_family;
        logic [15:0] xor_port;
        logic [63:0] xor_addr_hi;
        logic [63:0] xor_addr_lo;
        logic        plain_found;
        logic [15:0] plain_port;
        logic [31:0] plain_addr;
    } addr_info_t;

endpackage

`default_nettype wire

@@ sv/stunbr_header.sv @@
// Header checker: message type, magic cookie, transaction id, attribute length.
// Depends on stunbr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module stunbr_header
    import stunbr_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire step_t       step,
    input  wire logic [31:0] txid_high,
    input  wire logic [63:0] txid_low,
    output hdr_info_t        hdr_next
);

    logic [31:0] capture_reg, capture_next;
    logic [15:0] total_reg, total_next;
    status_t     fault_reg, fault_next;

    logic        in_hdr;
    logic [4:0]  hidx;
    logic [3:0]  id_byte;
    logic [95:0] txid_all;
    logic [7:0]  id_expect;

    assign in_hdr   = step.go && (step.idx < HDR_LEN);
    assign hidx     = step.idx[4:0];
    assign id_byte  = 4'(hidx - 5'd8);
    assign txid_all = {txid_high, txid_low};
    assign id_expect = 8'(txid_all >> (7'd88 - {id_byte, 3'b000}));

    always_comb begin
        capture_next = capture_reg;
        total_next   = total_reg;
        fault_next   = fault_reg;
        if (in_hdr) begin
            capture_next = {capture_reg[23:0], step.data};
            if (hidx == 5'd3) begin
                total_next = capture_next[15:0];
            end
            // first fault in wire order sticks
            priority if (fault_reg != ST_OK) begin
                fault_next = fault_reg;
            end else if (hidx == 5'd1 && capture_next[15:0] != MSG_BINDING_RESP) begin
                fault_next = ST_BAD_TYPE;
            end else if (hidx == 5'd7 && capture_next != STUN_COOKIE) begin
                fault_next = ST_BAD_MAGIC;
            end else if (hidx >= 5'd8 && step.data != id_expect) begin
                fault_next = ST_ID_MISMATCH;
            end else begin
                fault_next = fault_reg;
            end
        end
    end

    assign hdr_next.fault = fault_next;
    assign hdr_next.total = total_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            capture_reg <= '0;
            total_reg   <= '0;
            fault_reg   <= ST_OK;
        end else if (step.go && step.last) begin
            capture_reg <= '0;
            total_reg   <= '0;
            fault_reg   <= ST_OK;
        end else begin
            capture_reg <= capture_next;
            total_reg   <= total_next;
            fault_reg   <= fault_next;
        end
    end

endmodule

`default_nettype wire

@@ sv/stunbr_walker.sv @@
// Attribute walker: TLV framing with padding, value capture and address decode.
// Depends on stunbr_pkg and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "stun_binding_response_parser_defines.svh"

module stunbr_walker
    import stunbr_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire step_t       step,
    input  wire logic [15:0] attr_total,
    input  wire logic [31:0] txid_high,
    input  wire logic [63:0] txid_low,
    output addr_info_t       addr_next
);

    phase_t      phase_reg, phase_next;
    logic [15:0] kind_reg, kind_next;
    logic [15:0] length_reg, length_next;
    logic [15:0] offset_reg, offset_next;
    logic [7:0]  vb_reg [VAL_DEPTH];
    logic [7:0]  vb_eff [VAL_DEPTH];
    addr_info_t  found_reg, found_next;

    logic [POS_W-1:0] rel;
    logic        active;
    logic        vb_wr;
    logic [4:0]  vb_idx;
    logic [15:0] off_inc;
    logic [15:0] off_dec;
    logic [1:0]  pad;
    logic        decode;
    logic [7:0]  fam;
    logic [15:0] port_raw;
    logic [31:0] addr_v4;
    logic [63:0] addr_v6_hi;
    logic [63:0] addr_v6_lo;

    assign rel    = POS_W'(step.idx - HDR_LEN);
    assign active = step.go && (step.idx >= HDR_LEN) && (rel < POS_W'(attr_total));
    assign vb_idx = offset_reg[4:0];
    assign vb_wr  = active && (phase_reg == PH_VALUE) && (offset_reg < 16'(VAL_DEPTH));
    assign off_inc = offset_reg + 16'd1;
    assign off_dec = (offset_reg != 16'd0) ? offset_reg - 16'd1 : offset_reg;
    assign pad     = 2'(3'd4 - {1'b0, length_reg[1:0]});
    assign decode  = active && (phase_reg == PH_VALUE) && (off_inc >= length_reg);

    // merge the word being written so the closing byte is visible to decode
    always_comb begin
        for (int i = 0; i < VAL_DEPTH; i++) begin
            vb_eff[i] = (vb_wr && vb_idx == 5'(i)) ? step.data : vb_reg[i];
        end
    end

    assign fam        = vb_eff[1];
    assign port_raw   = {vb_eff[2], vb_eff[3]};
    assign addr_v4    = {vb_eff[4], vb_eff[5], vb_eff[6], vb_eff[7]};
    assign addr_v6_hi = {vb_eff[4], vb_eff[5], vb_eff[6], vb_eff[7],
                         vb_eff[8], vb_eff[9], vb_eff[10], vb_eff[11]};
    assign addr_v6_lo = {vb_eff[12], vb_eff[13], vb_eff[14], vb_eff[15],
                         vb_eff[16], vb_eff[17], vb_eff[18], vb_eff[19]};

    always_comb begin
        phase_next  = phase_reg;
        kind_next   = kind_reg;
        length_next = length_reg;
        offset_next = offset_reg;
        if (active) begin
            unique case (phase_reg)
                PH_HEAD: begin
                    if (offset_reg < 16'd2) begin
                        kind_next = {kind_reg[7:0], step.data};
                    end else begin
                        length_next = {length_reg[7:0], step.data};
                    end
                    if (off_inc == 16'd4) begin
                        offset_next = '0;
                        if (18'(rel) + 18'd1 + 18'(length_next) > 18'(attr_total)) begin
                            phase_next = PH_STOP;
                        end else if (length_next == 16'd0) begin
                            phase_next = PH_HEAD;
                        end else begin
                            phase_next = PH_VALUE;
                        end
                    end else begin
                        offset_next = off_inc;
                    end
                end
                PH_VALUE: begin
                    if (off_inc >= length_reg) begin
                        offset_next = {14'd0, pad};
                        phase_next  = (pad != 2'd0) ? PH_PAD : PH_HEAD;
                    end else begin
                        offset_next = off_inc;
                    end
                end
                PH_PAD: begin
                    offset_next = off_dec;
                    if (off_dec == 16'd0) begin
                        phase_next = PH_HEAD;
                    end
                end
                PH_STOP: begin
                    phase_next = PH_STOP;
                end
                default: begin
                    phase_next = phase_reg;
                end
            endcase
        end
    end

    always_comb begin
        found_next = found_reg;
        if (decode && length_reg >= V4_MIN_LEN) begin
            if (kind_reg == ATTR_XOR_MAPPED) begin
                if (fam == FAM_CODE_IPV4) begin
                    found_next.xor_found   = 1'b1;
                    found_next.xor_family  = FAMILY_IPV4;
                    found_next.xor_port    = port_raw ^ STUN_COOKIE[31:16];
                    found_next.xor_addr_hi = '0;
                    found_next.xor_addr_lo = {32'd0, addr_v4 ^ STUN_COOKIE};
                end else if (fam == FAM_CODE_IPV6 && length_reg >= V6_MIN_LEN) begin
                    found_next.xor_found   = 1'b1;
                    found_next.xor_family  = FAMILY_IPV6;
                    found_next.xor_port    = port_raw ^ STUN_COOKIE[31:16];
                    found_next.xor_addr_hi = addr_v6_hi ^ {STUN_COOKIE, txid_high};
                    found_next.xor_addr_lo = addr_v6_lo ^ txid_low;
                end
            end else if (kind_reg == ATTR_MAPPED && fam == FAM_CODE_IPV4) begin
                found_next.plain_found = 1'b1;
                found_next.plain_port  = port_raw;
                found_next.plain_addr  = addr_v4;
            end
        end
    end

    assign addr_next = found_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_HEAD;
            kind_reg   <= '0;
            length_reg <= '0;
            offset_reg <= '0;
            found_reg  <= '0;
        end else if (step.go && step.last) begin
            phase_reg  <= PH_HEAD;
            kind_reg   <= '0;
            length_reg <= '0;
            offset_reg <= '0;
            found_reg  <= '0;
        end else begin
            phase_reg  <= phase_next;
            kind_reg   <= kind_next;
            length_reg <= length_next;
            offset_reg <= offset_next;
            found_reg  <= found_next;
        end
    end

    // value bytes are read only after being written for the current attribute
    always_ff @(posedge aclk) begin
        if (vb_wr) begin
            vb_reg[vb_idx] <= step.data;
        end
    end

    `STUNBR_CHECK(a_pad_range, aclk, aresetn, (phase_reg == PH_PAD) |-> (offset_reg != 16'd0 && offset_reg <= 16'd3), "pad count out of range")
    `STUNBR_CHECK(a_head_range, aclk, aresetn, (phase_reg == PH_HEAD) |-> (offset_reg < 16'd4), "attribute header offset out of range")
    `STUNBR_CHECK(a_stop_holds, aclk, aresetn, (phase_reg == PH_STOP && !(step.go && step.last)) |=> (phase_reg == PH_STOP), "walk left stop before datagram end")

endmodule

`default_nettype wire

@@ sv/stun_binding_response_parser.sv @@
// Flow: an accepted word is held in the input register and processed from there; the result
// of the last word is loaded into the output register. Throughput: one word per cycle, except
// that a final word waits while an unread result is held; the single input and output registers set that figure.
// Reset: synchronous active-low aresetn clears all datagram state, both
// transaction id registers and the output valid; no clearing pass is needed.
// Top level of the STUN binding response parser; depends on stunbr_pkg,
// stunbr_header, stunbr_walker and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "stun_binding_response_parser_defines.svh"

module stun_binding_response_parser
    import stunbr_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,

    input  wire logic        s_valid,
    output      logic        s_ready,
    input  wire logic [7:0]  s_byte_in,
    input  wire logic        s_last,

    output      logic        m_valid,
    input  wire logic        m_ready,
    output      logic [2:0]  m_status,
    output      logic [1:0]  m_family,
    output      logic        m_from_xor,
    output      logic [15:0] m_port,
    output      logic [63:0] m_address_high,
    output      logic [63:0] m_address_low,

    input  wire logic        cfg_valid,
    output      logic        cfg_ready,
    input  wire logic        cfg_index,
    input  wire logic [63:0] cfg_data
);

    logic [31:0] txid_high_reg;
    logic [63:0] txid_low_reg;

    logic        in_valid_reg;
    logic [7:0]  byte_reg;
    logic        last_reg;

    logic [POS_W-1:0] pos_reg, pos_next;

    logic        m_valid_reg;
    status_t     m_status_reg, status_next;
    logic [1:0]  m_family_reg, family_next;
    logic        m_from_xor_reg, from_xor_next;
    logic [15:0] m_port_reg, port_next;
    logic [63:0] m_addr_hi_reg, addr_hi_next;
    logic [63:0] m_addr_lo_reg, addr_lo_next;

    logic        step_go;
    logic        res_load;
    step_t       step;
    hdr_info_t   hdr_next;
    addr_info_t  addr_next;

    // a non-final word never waits on the result side
    assign step_go  = in_valid_reg && (!last_reg || !m_valid_reg || m_ready);
    assign res_load = step_go && last_reg;
    assign s_ready  = !in_valid_reg || step_go;
    assign cfg_ready = 1'b1;

    assign pos_next = (pos_reg == POS_MAX) ? pos_reg : pos_reg + POS_W'(1);

    assign step.go   = step_go;
    assign step.data = byte_reg;
    assign step.last = last_reg;
    assign step.idx  = pos_reg;

    stunbr_header u_header (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (step),
        .txid_high (txid_high_reg),
        .txid_low  (txid_low_reg),
        .hdr_next  (hdr_next)
    );

    stunbr_walker u_walker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .step       (step),
        .attr_total (hdr_next.total),
        .txid_high  (txid_high_reg),
        .txid_low   (txid_low_reg),
        .addr_next  (addr_next)
    );

    always_comb begin
        status_next   = ST_OK;
        family_next   = FAMILY_NONE;
        from_xor_next = 1'b0;
        port_next     = '0;
        addr_hi_next  = '0;
        addr_lo_next  = '0;
        priority if (pos_next < HDR_LEN) begin
            status_next = ST_SHORT;
        end else if (hdr_next.fault != ST_OK) begin
            status_next = hdr_next.fault;
        end else if (18'(HDR_LEN) + 18'(hdr_next.total) > 18'(pos_next)) begin
            status_next = ST_OVERRUN;
        end else if (addr_next.xor_found) begin
            family_next   = addr_next.xor_family;
            from_xor_next = 1'b1;
            port_next     = addr_next.xor_port;
            addr_hi_next  = addr_next.xor_addr_hi;
            addr_lo_next  = addr_next.xor_addr_lo;
        end else if (addr_next.plain_found) begin
            family_next  = FAMILY_IPV4;
            port_next    = addr_next.plain_port;
            addr_lo_next = {32'd0, addr_next.plain_addr};
        end else begin
            status_next = ST_NO_ADDR;
        end
    end

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            txid_high_reg <= '0;
            txid_low_reg  <= '0;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_TXID_HIGH: txid_high_reg <= cfg_data[31:0];
                REG_TXID_LOW:  txid_low_reg  <= cfg_data;
                default:       txid_low_reg  <= txid_low_reg;
            endcase
        end
    end

    // input word register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            byte_reg <= s_byte_in;
            last_reg <= s_last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= '0;
        end else if (step_go) begin
            pos_reg <= last_reg ? '0 : pos_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_load) begin
            m_status_reg   <= status_next;
            m_family_reg   <= family_next;
            m_from_xor_reg <= from_xor_next;
            m_port_reg     <= port_next;
            m_addr_hi_reg  <= addr_hi_next;
            m_addr_lo_reg  <= addr_lo_next;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_status       = m_status_reg;
    assign m_family       = m_family_reg;
    assign m_from_xor     = m_from_xor_reg;
    assign m_port         = m_port_reg;
    assign m_address_high = m_addr_hi_reg;
    assign m_address_low  = m_addr_lo_reg;

    `STUNBR_CHECK(a_res_from_last, aclk, aresetn, $rose(m_valid_reg) |-> $past(step_go && last_reg), "result without a final word")
    `STUNBR_CHECK(a_fail_zero, aclk, aresetn, (m_valid_reg && m_status_reg != ST_OK) |-> (m_family_reg == FAMILY_NONE && m_port_reg == 16'd0 && m_addr_lo_reg == 64'd0 && !m_from_xor_reg), "failed result carries an address")
    `STUNBR_CHECK(a_pos_clear, aclk, aresetn, $past(step_go && last_reg) |-> (pos_reg == '0), "position not cleared after datagram end")
    `STUNBR_CHECK_ALWAYS(a_empty_ready, aclk, (!in_valid_reg) |-> s_ready, "input register empty but not ready")

endmodule

`default_nettype wire
